### design/vbl_pkg.sv
// vbl_pkg: shared constants, tag struct and arctangent table for the
// vector bearing/length CORDIC pipeline. No dependencies.

package vbl_pkg;

   localparam int DEF_DATA_WIDTH = 16;
   localparam int DEF_ITERATIONS = 16;
   localparam int ATAN_COUNT     = 24;
   localparam int GUARD_BITS     = 4;
   localparam int ANGLE_W        = 32;
   localparam int BEARING_W      = 16;
   localparam int LENGTH_W       = 16;
   localparam int GAIN_W         = 24;
   localparam int GAIN_FRAC      = 24;
   // 1/1.6467602581 in Q24
   localparam logic [GAIN_W-1:0]    INV_GAIN      = 24'd10188014;
   localparam logic [ANGLE_W-1:0]   HALF_TURN     = 32'h8000_0000;
   localparam logic [ANGLE_W-1:0]   BEARING_ROUND = 32'h0000_8000;
   localparam logic [BEARING_W-1:0] BEARING_NORTH = 16'd16384;
   localparam logic [BEARING_W-1:0] BEARING_SOUTH = 16'd49152;
   localparam logic [LENGTH_W-1:0]  LENGTH_MAX    = 16'hFFFF;

   typedef struct packed {
      logic dx_zero;
      logic dy_neg;
   } tag_type;

   // atan(2^-i) in units of 2^-32 turn
   function automatic logic [ANGLE_W-1:0] atan_step(input int idx);
      logic [ANGLE_W-1:0] val;
      case (idx)
         0:       val = 32'h20000000;
         1:       val = 32'h12E4051E;
         2:       val = 32'h09FB385B;
         3:       val = 32'h051111D4;
         4:       val = 32'h028B0D43;
         5:       val = 32'h0145D7E1;
         6:       val = 32'h00A2F61E;
         7:       val = 32'h00517C55;
         8:       val = 32'h0028BE53;
         9:       val = 32'h00145F2F;
         10:      val = 32'h000A2F98;
         11:      val = 32'h000517CC;
         12:      val = 32'h00028BE6;
         13:      val = 32'h000145F3;
         14:      val = 32'h0000A2F9;
         15:      val = 32'h0000517C;
         16:      val = 32'h000028BE;
         17:      val = 32'h0000145F;
         18:      val = 32'h00000A2F;
         19:      val = 32'h00000517;
         20:      val = 32'h0000028B;
         21:      val = 32'h00000145;
         22:      val = 32'h000000A2;
         23:      val = 32'h00000051;
         default: val = '0;
      endcase
      return val;
   endfunction

endpackage

### design/vector_bearing_and_length.sv
// vector_bearing_and_length: rectangular-to-polar conversion, one CORDIC
// micro-rotation per cell. Uses vbl_pkg, vbl_prerot, vbl_cell, vbl_scale.
//
//   channel | dir | tdata bits (low first)                 | notes
//   req_    | in  | delta_x[DW-1:0], delta_y, zero pad     | padded to bytes
//   rsp_    | out | bearing[15:0], length[31:16]           | one per transfer
//
// Cycles: one transfer accepted per clock while req_tready is high; stages
//   are the entry register, one cell per micro-rotation, two gain stages.
// Reset: synchronous, clears every stage valid bit; no clearing pass.
// Stalls: each stage advances when it is empty or its successor advances,
//   so bubbles collapse and req_tready drops only when every stage is full
//   and the result register is held by rsp_tready low.

module vector_bearing_and_length #(
   parameter int DATA_WIDTH = vbl_pkg::DEF_DATA_WIDTH,
   parameter int ITERATIONS = vbl_pkg::DEF_ITERATIONS
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_tvalid,
   output logic                                    req_tready,
   // delta_x, delta_y, zero pad
   input  logic [((2*DATA_WIDTH+7)/8)*8-1:0]       req_tdata,
   output logic                                    rsp_tvalid,
   input  logic                                    rsp_tready,
   // bearing[15:0], length[31:16]
   output logic [31:0]                             rsp_tdata
);
   import vbl_pkg::*;

   localparam int NC = (ITERATIONS < ATAN_COUNT) ? ITERATIONS : ATAN_COUNT;
   // signed, guard bits, half-turn negation and CORDIC growth
   localparam int XW = DATA_WIDTH + GUARD_BITS + 3;
   // entry stage, NC cells, two gain stages
   localparam int NS = NC + 3;

   logic signed [DATA_WIDTH-1:0] delta_x, delta_y;
   logic                         stage_v [0:NS-1];
   logic                         stage_en [0:NS-1];
   logic signed [XW-1:0]         x_pipe [0:NC];
   logic signed [XW-1:0]         y_pipe [0:NC];
   logic [ANGLE_W-1:0]           angle_pipe [0:NC];
   tag_type                      tag_pipe [0:NC];
   logic [BEARING_W-1:0]         bearing;
   logic [LENGTH_W-1:0]          length;

   assign delta_x = req_tdata[DATA_WIDTH-1:0];
   assign delta_y = req_tdata[2*DATA_WIDTH-1:DATA_WIDTH];

   // backward enable chain: a stage loads when empty or when drained
   always_comb begin
      stage_en[NS-1] = !stage_v[NS-1] || rsp_tready;
      for (int k = NS - 2; k >= 0; k--) begin
         stage_en[k] = !stage_v[k] || stage_en[k+1];
      end
   end

   assign req_tready = stage_en[0];

   vbl_prerot #(
      .DW(DATA_WIDTH),
      .XW(XW)
   ) u_prerot (
      .clock    (clock),
      .reset    (reset),
      .enable   (stage_en[0]),
      .up_valid (req_tvalid),
      .up_dx    (delta_x),
      .up_dy    (delta_y),
      .dn_valid (stage_v[0]),
      .dn_x     (x_pipe[0]),
      .dn_y     (y_pipe[0]),
      .dn_angle (angle_pipe[0]),
      .dn_tag   (tag_pipe[0])
   );

   // micro-rotation cells, cell i shifts by i
   for (genvar i = 0; i < NC; i++) begin : g_cell
      vbl_cell #(
         .XW(XW),
         .STAGE(i)
      ) u_cell (
         .clock    (clock),
         .reset    (reset),
         .enable   (stage_en[i+1]),
         .up_valid (stage_v[i]),
         .up_x     (x_pipe[i]),
         .up_y     (y_pipe[i]),
         .up_angle (angle_pipe[i]),
         .up_tag   (tag_pipe[i]),
         .dn_valid (stage_v[i+1]),
         .dn_x     (x_pipe[i+1]),
         .dn_y     (y_pipe[i+1]),
         .dn_angle (angle_pipe[i+1]),
         .dn_tag   (tag_pipe[i+1])
      );
   end

   // y of the last cell only steers rotations, nothing reads it after
   vbl_scale #(
      .XW(XW)
   ) u_scale (
      .clock      (clock),
      .reset      (reset),
      .enable_a   (stage_en[NC+1]),
      .enable_b   (stage_en[NC+2]),
      .up_valid   (stage_v[NC]),
      .up_x       (x_pipe[NC]),
      .up_angle   (angle_pipe[NC]),
      .up_tag     (tag_pipe[NC]),
      .mid_valid  (stage_v[NC+1]),
      .dn_valid   (stage_v[NC+2]),
      .dn_bearing (bearing),
      .dn_length  (length)
   );

   assign rsp_tvalid = stage_v[NS-1];
   assign rsp_tdata  = {length, bearing};

endmodule

### design/vbl_prerot.sv
// vbl_prerot: entry register of the pipeline. Scales the input by the guard
// bits and folds the left half plane over by a half turn. Uses vbl_pkg.

module vbl_prerot #(
   parameter int DW = 16,
   parameter int XW = 23
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   enable,
   input  logic                   up_valid,
   input  logic signed [DW-1:0]   up_dx,
   input  logic signed [DW-1:0]   up_dy,
   output logic                   dn_valid,
   output logic signed [XW-1:0]   dn_x,
   output logic signed [XW-1:0]   dn_y,
   output logic [31:0]            dn_angle,
   output vbl_pkg::tag_type       dn_tag
);
   import vbl_pkg::*;

   logic                  valid_ff;
   logic signed [XW-1:0]  x_ff, x_in, y_ff, y_in;
   logic [ANGLE_W-1:0]    angle_ff, angle_in;
   tag_type               tag_ff, tag_in;
   logic signed [XW-1:0]  dx_s, dy_s;
   logic                  left;

   always_comb begin
      dx_s = {{(XW-DW){up_dx[DW-1]}}, up_dx} <<< GUARD_BITS;
      dy_s = {{(XW-DW){up_dy[DW-1]}}, up_dy} <<< GUARD_BITS;
      left = up_dx[DW-1];
      x_in = left ? -dx_s : dx_s;
      y_in = left ? -dy_s : dy_s;
      angle_in = left ? HALF_TURN : '0;
      tag_in.dx_zero = (up_dx == '0);
      tag_in.dy_neg  = up_dy[DW-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         x_ff     <= x_in;
         y_ff     <= y_in;
         angle_ff <= angle_in;
         tag_ff   <= tag_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_x     = x_ff;
   assign dn_y     = y_ff;
   assign dn_angle = angle_ff;
   assign dn_tag   = tag_ff;

endmodule

### design/vbl_cell.sv
// vbl_cell: one CORDIC vectoring micro-rotation with its stage register.
// STAGE selects the shift and the arctangent step. Uses vbl_pkg.

module vbl_cell #(
   parameter int XW    = 23,
   parameter int STAGE = 0
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   enable,
   input  logic                   up_valid,
   input  logic signed [XW-1:0]   up_x,
   input  logic signed [XW-1:0]   up_y,
   input  logic [31:0]            up_angle,
   input  vbl_pkg::tag_type       up_tag,
   output logic                   dn_valid,
   output logic signed [XW-1:0]   dn_x,
   output logic signed [XW-1:0]   dn_y,
   output logic [31:0]            dn_angle,
   output vbl_pkg::tag_type       dn_tag
);
   import vbl_pkg::*;

   localparam logic [ANGLE_W-1:0] ATAN_K = atan_step(STAGE);

   logic                  valid_ff;
   logic signed [XW-1:0]  x_ff, x_in, y_ff, y_in;
   logic [ANGLE_W-1:0]    angle_ff, angle_in;
   tag_type               tag_ff;
   logic signed [XW-1:0]  xs, ys;

   always_comb begin
      xs = up_x >>> STAGE;
      ys = up_y >>> STAGE;
      if (!up_y[XW-1]) begin
         x_in     = up_x + ys;
         y_in     = up_y - xs;
         angle_in = up_angle + ATAN_K;
      end else begin
         x_in     = up_x - ys;
         y_in     = up_y + xs;
         angle_in = up_angle - ATAN_K;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         x_ff     <= x_in;
         y_ff     <= y_in;
         angle_ff <= angle_in;
         tag_ff   <= up_tag;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_x     = x_ff;
   assign dn_y     = y_ff;
   assign dn_angle = angle_ff;
   assign dn_tag   = tag_ff;

endmodule

### design/vbl_scale.sv
// vbl_scale: gain compensation of the magnitude (two partial products, then
// sum, round and saturate) and bearing rounding. Two register stages; the
// second is the result register. Uses vbl_pkg.

module vbl_scale #(
   parameter int XW = 23
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   enable_a,
   input  logic                   enable_b,
   input  logic                   up_valid,
   input  logic signed [XW-1:0]   up_x,
   input  logic [31:0]            up_angle,
   input  vbl_pkg::tag_type       up_tag,
   output logic                   mid_valid,
   output logic                   dn_valid,
   output logic [15:0]            dn_bearing,
   output logic [15:0]            dn_length
);
   import vbl_pkg::*;

   localparam int MW = XW - 1;
   localparam int LO = (MW + 1) / 2;
   localparam int HW = MW - LO;
   localparam int SW = MW + GAIN_W + 1;
   localparam int SH = GAIN_FRAC + GUARD_BITS;
   localparam logic [SW-1:0] ROUND = SW'(1) << (SH - 1);

   logic                      a_valid_ff, b_valid_ff;
   logic [LO+GAIN_W-1:0]      plo_ff, plo_in;
   logic [HW+GAIN_W-1:0]      phi_ff, phi_in;
   logic [BEARING_W-1:0]      bear_a_ff, bear_a_in, bear_b_ff;
   logic [LENGTH_W-1:0]       len_ff, len_in;
   logic [MW-1:0]             mag;
   logic [ANGLE_W-1:0]        angle_r;
   logic [SW-1:0]             sum, len_full;

   always_comb begin
      mag     = up_x[XW-1] ? '0 : up_x[MW-1:0];
      plo_in  = {{GAIN_W{1'b0}}, mag[LO-1:0]} * {{LO{1'b0}}, INV_GAIN};
      phi_in  = {{GAIN_W{1'b0}}, mag[MW-1:LO]} * {{HW{1'b0}}, INV_GAIN};
      angle_r = up_angle + BEARING_ROUND;
      if (up_tag.dx_zero) begin
         bear_a_in = up_tag.dy_neg ? BEARING_SOUTH : BEARING_NORTH;
      end else begin
         bear_a_in = angle_r[ANGLE_W-1 -: BEARING_W];
      end
   end

   always_comb begin
      sum = {1'b0, phi_ff, {LO{1'b0}}}
            + {{(SW-LO-GAIN_W){1'b0}}, plo_ff} + ROUND;
      len_full = sum >> SH;
      len_in   = (|len_full[SW-1:LENGTH_W]) ? LENGTH_MAX : len_full[LENGTH_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         if (enable_a) begin
            a_valid_ff <= up_valid;
         end
         if (enable_b) begin
            b_valid_ff <= a_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable_a) begin
         plo_ff    <= plo_in;
         phi_ff    <= phi_in;
         bear_a_ff <= bear_a_in;
      end
      if (enable_b) begin
         len_ff    <= len_in;
         bear_b_ff <= bear_a_ff;
      end
   end

   assign mid_valid  = a_valid_ff;
   assign dn_valid   = b_valid_ff;
   assign dn_bearing = bear_b_ff;
   assign dn_length  = len_ff;

endmodule

### design/vbl_checker.sv
// vbl_checker: port-level assertions for vector_bearing_and_length, bound
// to the top level. No package dependency.

module vbl_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata
);

   // a held result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("rsp_tvalid dropped while stalled");

   // a held result keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("rsp_tdata changed while stalled");

   // reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result offered right after reset");

   // input backpressure only when the result register is held
   a_bp_source: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("req_tready low without a stalled result");

   // an offered result carries a fully known payload
   a_rsp_known: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !$isunknown(rsp_tdata))
      else $error("rsp_tdata unknown while offered");

endmodule

bind vector_bearing_and_length vbl_checker u_vbl_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
